/* rtl/prn_pkg.sv */
// Package for the perspective remap address generator.
// Holds shared widths, image bounds and the config register indexes; no dependencies.
package prn_pkg;
    localparam int COEF_W = 56;
    localparam int COORD_W = 11;
    localparam int INDEX_W = 22;
    localparam int IMAGE_WIDTH = 2048;
    localparam int IMAGE_HEIGHT = 2048;
    // Projected sums: 56-bit coef times 13-bit signed value plus margin.
    localparam int SUM_W = 72;
    localparam int QBITS = 12;
    // Rounding numerator/denominator (2n+d, 2d), with room for the divisor
    // shifted up by the top quotient bit.
    localparam int DIV_W = SUM_W + QBITS;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_M00 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M02 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M10 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M11 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_M12 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_M20 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_M21 = 3'd7;

    localparam logic signed [COEF_W-1:0] Q_ONE = 56'sd4294967296;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
    } coef_set_t;

    // One step of the restoring division carried down the pipe.
    typedef struct packed {
        logic                    ok;
        logic [DIV_W-1:0]        numx;
        logic [DIV_W-1:0]        numy;
        logic [DIV_W-1:0]        den;
        logic [QBITS-1:0]        qx;
        logic [QBITS-1:0]        qy;
    } div_state_t;
endpackage

/* rtl/prn_project.sv */
// Projection stages: two products per row, then the row sums with the offsets.
// Depends on prn_pkg.
module prn_project (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  prn_pkg::coef_set_t                 coefs,
    input  logic                               in_valid,
    input  logic [prn_pkg::COORD_W-1:0]        in_x,
    input  logic [prn_pkg::COORD_W-1:0]        in_y,
    output logic                               out_valid,
    output prn_pkg::div_state_t                out_state
);
    import prn_pkg::*;

    typedef logic signed [SUM_W-1:0] sum_t;

    logic v1_reg, v2_reg;
    sum_t px0_reg, px1_reg, py0_reg, py1_reg, pz0_reg, pz1_reg;
    div_state_t st_reg, st_next;

    logic signed [COORD_W+1:0] xs, ys;
    sum_t nx, ny, nz, numx, numy;

    assign xs = {2'b00, in_x};
    assign ys = {2'b00, in_y};

    // Stage 1: the six products (each 56 x 13 signed).
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg <= SUM_W'(coefs.m00 * xs);
            px1_reg <= SUM_W'(coefs.m01 * ys);
            py0_reg <= SUM_W'(coefs.m10 * xs);
            py1_reg <= SUM_W'(coefs.m11 * ys);
            pz0_reg <= SUM_W'(coefs.m20 * xs);
            pz1_reg <= SUM_W'(coefs.m21 * ys);
        end
    end

    // Stage 2: sums and rounding setup; the offsets are stable config.
    always_comb
    begin
        nx = px0_reg + px1_reg + SUM_W'(coefs.m02);
        ny = py0_reg + py1_reg + SUM_W'(coefs.m12);
        nz = pz0_reg + pz1_reg + SUM_W'(Q_ONE);
        numx = (nx <<< 1) + nz;
        numy = (ny <<< 1) + nz;
        st_next.ok = !nz[SUM_W-1] && (nz != '0) && !numx[SUM_W-1] && !numy[SUM_W-1];
        st_next.numx = DIV_W'(unsigned'(numx));
        st_next.numy = DIV_W'(unsigned'(numy));
        st_next.den = DIV_W'(unsigned'(nz)) << 1;
        st_next.qx = '0;
        st_next.qy = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_state = st_reg;
endmodule

/* rtl/prn_divide.sv */
// Pipelined restoring divider: two quotient bits per stage, both axes at once.
// Depends on prn_pkg.
module prn_divide (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  prn_pkg::div_state_t   in_state,
    output logic                  out_valid,
    output prn_pkg::div_state_t   out_state
);
    import prn_pkg::*;

    localparam int BPS = 2;
    localparam int NST = QBITS / BPS;

    div_state_t st_reg [NST];
    logic       v_reg  [NST];
    div_state_t st_next [NST];

    always_comb
    begin
        for (int s = 0; s < NST; s++)
        begin
            st_next[s] = (s == 0) ? in_state : st_reg[(s == 0) ? 0 : s - 1];
            for (int k = 0; k < BPS; k++)
            begin
                // Bit position counts down from the top quotient bit.
                if (st_next[s].numx >= (st_next[s].den << (QBITS - 1 - s * BPS - k)))
                begin
                    st_next[s].numx = st_next[s].numx
                        - (st_next[s].den << (QBITS - 1 - s * BPS - k));
                    st_next[s].qx[QBITS - 1 - s * BPS - k] = 1'b1;
                end
                if (st_next[s].numy >= (st_next[s].den << (QBITS - 1 - s * BPS - k)))
                begin
                    st_next[s].numy = st_next[s].numy
                        - (st_next[s].den << (QBITS - 1 - s * BPS - k));
                    st_next[s].qy[QBITS - 1 - s * BPS - k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NST; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_state = st_reg[NST-1];
endmodule

/* rtl/perspective_remap_nearest_unit.sv */
// Perspective remap address generator, nearest neighbor: top level.
// Depends on prn_pkg, prn_project and prn_divide.
//
// Each request carries one output pixel coordinate and yields one source address.
// The block accepts one request per clock while the output is not stalled. A
// request passes one product stage, one sum stage, six divider stages of two
// quotient bits, one range check stage and one output register. The pipeline
// advances whenever the output register is empty or being taken. Coefficients
// are Q23.32 and must only be written while no request is in flight.
module perspective_remap_nearest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [55:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // dst_x [10:0], dst_y [21:11], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // src_x [10:0], src_y [21:11], inside_res [22],
                                   // src_index [44:23], zero fill
);
    import prn_pkg::*;

    coef_set_t  coef_reg;
    logic       adv;
    logic       pv, dv, cv_reg, ov_reg;
    div_state_t ps, ds;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic               cin_reg;
    logic [47:0]        odata_reg;
    logic               ok;
    logic [INDEX_W-1:0] idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{m00: Q_ONE, m11: Q_ONE, default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_M00: coef_reg.m00 <= cfg_data;
                REG_M01: coef_reg.m01 <= cfg_data;
                REG_M02: coef_reg.m02 <= cfg_data;
                REG_M10: coef_reg.m10 <= cfg_data;
                REG_M11: coef_reg.m11 <= cfg_data;
                REG_M12: coef_reg.m12 <= cfg_data;
                REG_M20: coef_reg.m20 <= cfg_data;
                REG_M21: coef_reg.m21 <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv = !ov_reg || m_tready;
    assign s_tready = adv;

    prn_project u_project (
        .clk(clk), .rst_n(rst_n), .adv(adv), .coefs(coef_reg),
        .in_valid(s_tvalid), .in_x(s_tdata[10:0]), .in_y(s_tdata[21:11]),
        .out_valid(pv), .out_state(ps)
    );

    prn_divide u_divide (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(pv), .in_state(ps),
        .out_valid(dv), .out_state(ds)
    );

    // Remainder must be below the divisor, else the quotient overflowed.
    always_comb
    begin
        ok = ds.ok && (ds.numx < ds.den) && (ds.numy < ds.den)
            && ({1'b0, ds.qx} < (QBITS + 1)'(IMAGE_WIDTH))
            && ({1'b0, ds.qy} < (QBITS + 1)'(IMAGE_HEIGHT));
        idx = INDEX_W'(cy_reg * IMAGE_WIDTH + cx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cin_reg <= ok;
            cx_reg <= ok ? ds.qx[COORD_W-1:0] : '0;
            cy_reg <= ok ? ds.qy[COORD_W-1:0] : '0;
            odata_reg <= {3'b000, idx, cin_reg, cy_reg, cx_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg <= dv;
            ov_reg <= cv_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = odata_reg;
endmodule
